@@ design/md5h_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5h_pkg
// Shared types, constants and round tables for the MD5 hash engine.
// ----------------------------------------------------------------------------
package md5h_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } md5h_item_t;

    typedef struct packed {
        logic [63:0] digest_first_half;
        logic [63:0] digest_second_half;
    } md5h_digest_t;

    // write request into the block buffer
    typedef struct packed {
        logic        we;
        logic [3:0]  idx;
        logic [31:0] data;
        logic [3:0]  strb;
    } md5h_blk_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_EMIT
    } md5h_state_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [5:0]  LAST_POS   = 6'd63;
    localparam logic [5:0]  LEN_POS_M1 = 6'd55;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [3:0]  LEN_LO_IDX = 4'd14;
    localparam logic [3:0]  LEN_HI_IDX = 4'd15;

    function automatic logic [31:0] md5h_sine(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // rotate amount, selected by phase and round within a group of four
    function automatic logic [4:0] md5h_shift(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word used by each round (mod 16 arithmetic)
    function automatic logic [3:0] md5h_msg_index(input logic [5:0] r);
        logic [3:0] r4;
        logic [3:0] g;
        r4 = r[3:0];
        case (r[5:4])
            2'd0:    g = r4;
            2'd1:    g = r4 * 4'd5 + 4'd1;
            2'd2:    g = r4 * 4'd3 + 4'd5;
            2'd3:    g = r4 * 4'd7;
            default: g = r4;
        endcase
        return g;
    endfunction

endpackage

@@ design/md5_hash_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_hash_engine
// Streaming MD5 digest: one byte per request, digest on end of message.
//
//   channel | direction | payload        | handshake
//   --------+-----------+----------------+------------------------------
//   item    | in        | md5h_item_t    | item_valid / item_stall
//   digest  | out       | md5h_digest_t  | digest_valid / digest_stall
//
// A byte request is taken while the sequencer is idle; every 64th byte runs
// the 64 rounds of the shared round unit plus the fold into the chaining
// words. An end request writes the padding bytes (up to 64) and the two
// length words, compresses the final block(s) and then emits the digest.
// item_stall is high whenever the sequencer is not idle. The digest sits in
// an output register, so a stalled digest blocks only the next emit.
// ----------------------------------------------------------------------------
module md5_hash_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  md5h_pkg::md5h_item_t  item,
    output logic                  digest_valid,
    input  logic                  digest_stall,
    output md5h_pkg::md5h_digest_t digest
);
    import md5h_pkg::*;

    md5h_state_t  state_reg, state_next;
    md5h_state_t  ret_reg, ret_next;
    logic [5:0]   round_reg, round_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  count_reg, count_next;
    logic [31:0]  chain_reg [0:3];
    logic [31:0]  chain_next [0:3];
    logic [31:0]  wa_reg, wb_reg, wc_reg, wd_reg;
    logic [31:0]  wa_next, wb_next, wc_next, wd_next;
    md5h_digest_t out_reg, out_next;
    logic         out_valid_reg, out_valid_next;

    md5h_blk_wr_t blk_wr;
    logic [31:0]  msg_word;
    logic [31:0]  new_b;
    logic         byte_wr;
    logic [7:0]   byte_val;
    logic [63:0]  bit_len;
    logic         accept;

    md5h_block_buf u_buf (
        .clk     (clk),
        .wr      (blk_wr),
        .rd_idx  (md5h_msg_index(round_reg)),
        .rd_data (msg_word)
    );

    md5h_round u_round (
        .round    (round_reg),
        .a        (wa_reg),
        .b        (wb_reg),
        .c        (wc_reg),
        .d        (wd_reg),
        .msg_word (msg_word),
        .new_b    (new_b)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;
    assign bit_len      = {count_reg[60:0], 3'b000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            round_reg     <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            chain_reg[0]  <= IV_A;
            chain_reg[1]  <= IV_B;
            chain_reg[2]  <= IV_C;
            chain_reg[3]  <= IV_D;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            round_reg     <= round_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            for (int i = 0; i < 4; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg  <= wa_next;
        wb_reg  <= wb_next;
        wc_reg  <= wc_next;
        wd_reg  <= wd_next;
        out_reg <= out_next;
    end

    // byte writes go to the current fill position; lane 0 clears the word
    always_comb
    begin
        blk_wr = '0;
        if (byte_wr)
        begin
            blk_wr.we  = 1'b1;
            blk_wr.idx = fill_reg[5:2];
            if (fill_reg[1:0] == 2'd0)
            begin
                blk_wr.data = {24'd0, byte_val};
                blk_wr.strb = 4'hf;
            end
            else
            begin
                blk_wr.data = {4{byte_val}};
                blk_wr.strb = 4'b0001 << fill_reg[1:0];
            end
        end
        else if (state_reg == ST_LEN_LO)
        begin
            blk_wr.we   = 1'b1;
            blk_wr.idx  = LEN_LO_IDX;
            blk_wr.data = bit_len[31:0];
            blk_wr.strb = 4'hf;
        end
        else if (state_reg == ST_LEN_HI)
        begin
            blk_wr.we   = 1'b1;
            blk_wr.idx  = LEN_HI_IDX;
            blk_wr.data = bit_len[63:32];
            blk_wr.strb = 4'hf;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        round_next     = round_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        for (int i = 0; i < 4; i++)
        begin
            chain_next[i] = chain_reg[i];
        end
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        wc_next        = wc_reg;
        wd_next        = wd_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && digest_stall;
        byte_wr        = 1'b0;
        byte_val       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.byte_present)
                begin
                    byte_wr    = 1'b1;
                    byte_val   = item.data_byte;
                    count_next = count_reg + 64'd1;
                    fill_next  = fill_reg + 6'd1;
                    if (fill_reg == LAST_POS)
                    begin
                        state_next = ST_ROUND;
                        ret_next   = item.end_of_message ? ST_PAD_MARK : ST_IDLE;
                    end
                    else if (item.end_of_message)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
                else if (accept && item.end_of_message)
                begin
                    state_next = ST_PAD_MARK;
                end
            end

            ST_PAD_MARK, ST_PAD_ZERO:
            begin
                byte_wr   = 1'b1;
                byte_val  = (state_reg == ST_PAD_MARK) ? PAD_BYTE : 8'd0;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == LAST_POS)
                begin
                    // no room for the length: finish this block, pad another
                    state_next = ST_ROUND;
                    ret_next   = ST_PAD_ZERO;
                end
                else if (fill_reg == LEN_POS_M1)
                begin
                    state_next = ST_LEN_LO;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end

            ST_LEN_LO:
            begin
                state_next = ST_LEN_HI;
            end

            ST_LEN_HI:
            begin
                state_next = ST_ROUND;
                ret_next   = ST_EMIT;
            end

            ST_ROUND:
            begin
                wa_next    = wd_reg;
                wd_next    = wc_reg;
                wc_next    = wb_reg;
                wb_next    = new_b;
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD:
            begin
                chain_next[0] = chain_reg[0] + wa_reg;
                chain_next[1] = chain_reg[1] + wb_reg;
                chain_next[2] = chain_reg[2] + wc_reg;
                chain_next[3] = chain_reg[3] + wd_reg;
                state_next    = ret_reg;
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !digest_stall)
                begin
                    out_next.digest_first_half  = {chain_reg[1], chain_reg[0]};
                    out_next.digest_second_half = {chain_reg[3], chain_reg[2]};
                    out_valid_next = 1'b1;
                    chain_next[0]  = IV_A;
                    chain_next[1]  = IV_B;
                    chain_next[2]  = IV_C;
                    chain_next[3]  = IV_D;
                    count_next     = '0;
                    fill_next      = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // every compression starts from the chaining words at round zero
        if (state_next == ST_ROUND && state_reg != ST_ROUND)
        begin
            wa_next    = chain_reg[0];
            wb_next    = chain_reg[1];
            wc_next    = chain_reg[2];
            wd_next    = chain_reg[3];
            round_next = '0;
        end
    end

endmodule

@@ design/md5h_block_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5h_block_buf
// Sixteen-word message block store with byte-lane writes.
// ----------------------------------------------------------------------------
module md5h_block_buf (
    input  logic                 clk,
    input  md5h_pkg::md5h_blk_wr_t wr,
    input  logic [3:0]           rd_idx,
    output logic [31:0]          rd_data
);
    import md5h_pkg::*;

    logic [31:0] words_reg [0:15];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (wr.strb[i])
                begin
                    words_reg[wr.idx][8*i +: 8] <= wr.data[8*i +: 8];
                end
            end
        end
    end

    assign rd_data = words_reg[rd_idx];

endmodule

@@ design/md5h_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5h_round
// One MD5 step: boolean function, constant add, rotate, add into B.
// ----------------------------------------------------------------------------
module md5h_round (
    input  logic [5:0]  round,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] msg_word,
    output logic [31:0] new_b
);
    import md5h_pkg::*;

    logic [31:0] f;
    logic [31:0] sum;
    logic [31:0] rot;
    logic [4:0]  s;

    always_comb
    begin
        case (round[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
    end

    assign s     = md5h_shift(round);
    assign sum   = a + f + msg_word + md5h_sine(round);
    // s is never zero, so the right shift stays below 32
    assign rot   = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    assign new_b = b + rot;

endmodule
